// File: sv/fdec_pkg.sv
// ----------------------------------------------------------------------------
// Decimating FIR package
// Shared widths, the symmetric tap sets, and the control bundle for the MAC.
// ----------------------------------------------------------------------------
package fdec_pkg;

	localparam int TAPS        = 65;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 18;
	localparam int OUT_BITS    = 26;
	localparam int HALF_TAPS   = 33;
	localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS    = PROD_BITS + 7;
	localparam int STEP_BITS   = $clog2(TAPS);
	localparam int PHASE_BITS  = 5;
	localparam int FACTOR_BITS = 6;
	localparam int CFG_IDX_BITS = 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_DECIM_FACTOR = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_SELECT  = 8'd1;

	localparam logic [FACTOR_BITS-1:0] FACTOR_MAX   = 6'd32;
	localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 6'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} fdec_state_t;

	typedef struct packed {
		logic clear;   // start a new sum
		logic mul_en;  // a sample/tap pair is presented this cycle
	} mac_ctrl_t;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// Taps 0..32 of each set; tap k equals tap 64-k.
	localparam coef_t LP15K [HALF_TAPS] = '{
		18'sd0, 18'sd52, 18'sd102, 18'sd143, 18'sd158, 18'sd131, 18'sd49, -18'sd89,
		-18'sd263, -18'sd430, -18'sd528, -18'sd495, -18'sd290, 18'sd87, 18'sd578,
		18'sd1069, 18'sd1405, 18'sd1432, 18'sd1040, 18'sd211, -18'sd950, -18'sd2214,
		-18'sd3248, -18'sd3681, -18'sd3183, -18'sd1546, 18'sd1248, 18'sd4994,
		18'sd9277, 18'sd13533, 18'sd17150, 18'sd19577, 18'sd20431
	};

	localparam coef_t LP2K5 [HALF_TAPS] = '{
		18'sd69, 18'sd83, 18'sd104, 18'sd132, 18'sd170, 18'sd221, 18'sd284, 18'sd362,
		18'sd456, 18'sd567, 18'sd695, 18'sd840, 18'sd1002, 18'sd1181, 18'sd1374,
		18'sd1581, 18'sd1799, 18'sd2027, 18'sd2261, 18'sd2499, 18'sd2738, 18'sd2974,
		18'sd3205, 18'sd3426, 18'sd3634, 18'sd3826, 18'sd4000, 18'sd4152, 18'sd4280,
		18'sd4381, 18'sd4455, 18'sd4500, 18'sd4515
	};

	// Tap k of the selected set; taps beyond the last one are zero.
	function automatic coef_t tap_value(input logic [STEP_BITS-1:0] k, input logic sel);
		logic [STEP_BITS-1:0] idx;
		coef_t                c;
		idx = (k <= STEP_BITS'(HALF_TAPS - 1)) ? k : STEP_BITS'(2 * (HALF_TAPS - 1)) - k;
		c = sel ? LP2K5[idx[5:0]] : LP15K[idx[5:0]];
		if (k > STEP_BITS'(2 * (HALF_TAPS - 1))) begin
			c = '0;
		end
		return c;
	endfunction

endpackage

// File: sv/fdec_cell.sv
// ----------------------------------------------------------------------------
// Sample cell
// One stage of the sample ring: takes the upstream word on a new sample,
// or the downstream word while the ring rotates past the MAC.
// ----------------------------------------------------------------------------
module fdec_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic                                   rotate,
	input  logic signed [fdec_pkg::SAMPLE_BITS-1:0] load_in,
	input  logic signed [fdec_pkg::SAMPLE_BITS-1:0] rot_in,
	output logic signed [fdec_pkg::SAMPLE_BITS-1:0] q
);

	logic signed [fdec_pkg::SAMPLE_BITS-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (load) begin
			sample_q <= load_in;
		end else if (rotate) begin
			sample_q <= rot_in;
		end
	end

	assign q = sample_q;

endmodule

// File: sv/fdec_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// A registered multiplier followed by the accumulator for one filter sum.
// ----------------------------------------------------------------------------
module fdec_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fdec_pkg::mac_ctrl_t                    ctrl,
	input  logic signed [fdec_pkg::SAMPLE_BITS-1:0] sample,
	input  fdec_pkg::coef_t                        coef,
	output logic signed [fdec_pkg::ACC_BITS-1:0]    acc
);

	logic signed [fdec_pkg::PROD_BITS-1:0] prod_s1;
	logic                                  prod_vld_s1;
	logic signed [fdec_pkg::ACC_BITS-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctrl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= sample * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + {{(fdec_pkg::ACC_BITS - fdec_pkg::PROD_BITS){prod_s1[
				fdec_pkg::PROD_BITS-1]}}, prod_s1};
		end
	end

	assign acc = acc_q;

endmodule

// File: sv/fir_decimator_65tap_top.sv
// A new sample is taken only in the idle state, once the single MAC has
// visited all 65 taps in turn while the sample ring rotates past it. A kept word that
// finds the output register still full holds the block until that word leaves.
// Reset: history and phase clear to zero, decim_factor to 4, coef_select to 0.
// ----------------------------------------------------------------------------
// Decimating 65-tap FIR filter
// Symmetric lowpass FIR with selectable tap set, keeping one output in every
// decim_factor input samples.
// ----------------------------------------------------------------------------
module fir_decimator_65tap_top (
	input  logic                                           clk,
	input  logic                                           arst_n,
	// sample channel
	input  logic                                           in_valid,
	output logic                                           in_ready,
	input  logic signed [fdec_pkg::SAMPLE_BITS-1:0]        sample_in,
	// result channel
	output logic                                           out_valid,
	input  logic                                           out_ready,
	output logic signed [fdec_pkg::OUT_BITS-1:0]           filtered,
	// configuration channel
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [fdec_pkg::CFG_IDX_BITS-1:0]              cfg_index,
	input  logic [fdec_pkg::FACTOR_BITS-1:0]               cfg_data
);

	// The sample ring holds the new sample in cell 0 and the past samples in
	// cells 1 to 64, newest first. A new word shifts the ring by one place,
	// dropping the oldest sample once this sum has used it. During the sum
	// the ring rotates towards cell 0 once per cycle, so cell 0 presents the
	// sample for tap k at step k; after 65 steps it is back in order.

	fdec_pkg::fdec_state_t state_q, state_d;

	logic [fdec_pkg::STEP_BITS-1:0]   step_q;
	logic [fdec_pkg::PHASE_BITS-1:0]  phase_q;
	logic [fdec_pkg::FACTOR_BITS-1:0] factor_q;
	logic                             coef_sel_q;
	logic                             emit_q;
	logic                             out_valid_q;
	logic signed [fdec_pkg::OUT_BITS-1:0] filtered_q;

	logic in_accept;
	logic rotate;
	logic out_load;
	fdec_pkg::mac_ctrl_t mac_ctrl;

	logic signed [fdec_pkg::SAMPLE_BITS-1:0] ring [fdec_pkg::TAPS];
	logic signed [fdec_pkg::ACC_BITS-1:0]    acc;
	logic [fdec_pkg::ACC_BITS-1:0]           rounded;

	logic [fdec_pkg::FACTOR_BITS-1:0] eff_factor;
	logic [fdec_pkg::FACTOR_BITS-1:0] phase_next;

	assign in_ready  = (state_q == fdec_pkg::ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign rotate    = (state_q == fdec_pkg::ST_RUN);

	// Sample ring.
	genvar gi;
	generate
		for (gi = 0; gi < fdec_pkg::TAPS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				fdec_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.load    (in_accept),
					.rotate  (rotate),
					.load_in (sample_in),
					.rot_in  (ring[1]),
					.q       (ring[0])
				);
			end else if (gi == fdec_pkg::TAPS - 1) begin : g_tail
				fdec_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.load    (in_accept),
					.rotate  (rotate),
					.load_in (ring[gi-1]),
					.rot_in  (ring[0]),
					.q       (ring[gi])
				);
			end else begin : g_mid
				fdec_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.load    (in_accept),
					.rotate  (rotate),
					.load_in (ring[gi-1]),
					.rot_in  (ring[gi+1]),
					.q       (ring[gi])
				);
			end
		end
	endgenerate

	// The MAC takes cell 0 with the tap for the current step.
	assign mac_ctrl.clear  = in_accept;
	assign mac_ctrl.mul_en = rotate;

	fdec_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (ring[0]),
		.coef   (fdec_pkg::tap_value(step_q, coef_sel_q)),
		.acc    (acc)
	);

	// Round half up, drop the fractional bits of the taps and keep 26 bits.
	assign rounded = acc + (fdec_pkg::ACC_BITS'(1) << (fdec_pkg::COEF_BITS - 2));

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdec_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			fdec_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = fdec_pkg::ST_RUN;
				end
			end
			fdec_pkg::ST_RUN: begin
				if (step_q == fdec_pkg::STEP_BITS'(fdec_pkg::TAPS - 1)) begin
					state_d = fdec_pkg::ST_DRAIN;
				end
			end
			fdec_pkg::ST_DRAIN: begin
				state_d = fdec_pkg::ST_FINISH;
			end
			fdec_pkg::ST_FINISH: begin
				// A decimated-away sample leaves at once; a kept one waits
				// for the output register to be free.
				if (!emit_q) begin
					state_d = fdec_pkg::ST_IDLE;
				end else if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = fdec_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdec_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (in_accept) begin
			step_q <= '0;
		end else if (rotate) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Decimation phase: a factor of zero acts as one, above 32 as 32. The
	// phase wraps to zero when its successor reaches the factor, which also
	// covers a factor lowered below the current phase.
	always_comb begin
		eff_factor = factor_q;
		if (factor_q == '0) begin
			eff_factor = fdec_pkg::FACTOR_BITS'(1);
		end else if (factor_q > fdec_pkg::FACTOR_MAX) begin
			eff_factor = fdec_pkg::FACTOR_MAX;
		end
		phase_next = {1'b0, phase_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			emit_q  <= 1'b0;
		end else if (in_accept) begin
			emit_q  <= (phase_q == '0);
			phase_q <= (phase_next >= eff_factor) ? '0 : phase_next[fdec_pkg::PHASE_BITS-1:0];
		end
	end

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q   <= fdec_pkg::FACTOR_RESET;
			coef_sel_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fdec_pkg::REG_DECIM_FACTOR: factor_q   <= cfg_data;
				fdec_pkg::REG_COEF_SELECT:  coef_sel_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Output register: a finished word waits here while the next sample is
	// already being filtered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= rounded[fdec_pkg::COEF_BITS-1 +: fdec_pkg::OUT_BITS];
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

endmodule
